>>> rtl/core/assert_macros.svh
// Assertion macros shared by the gradient table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define GLF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define GLF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/glf_pkg.sv
// Package: commands, constants and premultiply helper for the gradient table.
package glf_pkg;

  localparam int OFFSET_W = 17;
  localparam int COLOR_W  = 32;
  localparam int INDEX_W  = 10;
  localparam int LUT_W    = 11;
  localparam int DVD_W    = 31;

  localparam logic [LUT_W-1:0]    LUT_SIZE_RST = 11'd256;
  localparam logic [OFFSET_W-1:0] OFFSET_ONE   = 17'h10000;
  localparam logic [31:0]         HALF_STEP    = 32'h0040_0000;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_FINISH = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  // x * a / 255 with rounding, per color channel
  function automatic logic [7:0] mul_chan(input logic [7:0] x, input logic [7:0] a);
    logic [15:0] t;
    logic [15:0] u;
    t = 16'(x) * 16'(a) + 16'h0080;
    u = t + {8'h00, t[15:8]};
    return u[15:8];
  endfunction

  function automatic logic [31:0] premul(input logic [31:0] c);
    logic [7:0] a;
    a = c[31:24];
    return {a, mul_chan(c[23:16], a), mul_chan(c[15:8], a), mul_chan(c[7:0], a)};
  endfunction

endpackage

>>> rtl/core/gradient_lut_fill_prgb32.sv
// Top level: gradient lookup table builder, premultiplied ARGB32.
//
//  channel | handshake               | payload
//  --------+-------------------------+----------------------------------------
//  in      | in_valid_i / in_stall_o | command_i, offset_i, color_i, index_i
//  out     | out_valid_o/out_stall_i | read_data_o, error_o
//  cfg     | cfg_valid_i/cfg_ready_o | lut_size_i
//
//  Add stop: writes each span entry in turn; a non-constant span first
//  runs the shared serial divider once per channel. Finish: writes each tail
//  entry. Read: data comes from the registered table read.
//  Reset clears the sequencer and the stop state; the table holds no reset.
//  An item is taken while a result waits; the sequencer holds before output
//  while out_stall_i keeps the previous result.
`include "assert_macros.svh"

module gradient_lut_fill_prgb32 #(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   command_i,
  input  logic [glf_pkg::OFFSET_W-1:0] offset_i,
  input  logic [glf_pkg::COLOR_W-1:0]  color_i,
  input  logic [glf_pkg::INDEX_W-1:0]  index_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [glf_pkg::COLOR_W-1:0]  read_data_o,
  output logic                         error_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [glf_pkg::LUT_W-1:0]    lut_size_i
);
  import glf_pkg::*;

  localparam int AW  = $clog2(MAX_ENTRIES);
  localparam int NW  = ($clog2(MAX_ENTRIES + 1) > LUT_W) ? $clog2(MAX_ENTRIES + 1) : LUT_W;
  localparam int PW  = AW + 8;
  localparam int PRW = OFFSET_W + AW;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_SPAN, S_CONST, S_START, S_DIV, S_DIVWAIT, S_INTERP,
    S_FIN, S_FIN0, S_READ, S_RWAIT, S_DONE
  } state_e;

  state_e               state_q;
  logic [OFFSET_W-1:0]  off_q;
  logic [COLOR_W-1:0]   color_q;
  logic [INDEX_W-1:0]   index_q;
  logic [LUT_W-1:0]     lut_size_q;
  logic [COLOR_W-1:0]   prev_color_q;
  logic [PW-1:0]        prev_pos_q;
  logic [NW-1:0]        wp_q;
  logic [COLOR_W-1:0]   first_q;
  logic                 stop_seen_q;
  logic [PRW-1:0]       prod_q;
  logic [COLOR_W-1:0]   c0_q;
  logic [AW-1:0]        addr_q;
  logic [AW-1:0]        len_q;
  logic [AW-1:0]        rem_q;
  logic [NW-1:0]        fin_k_q;
  logic [1:0]           ch_q;
  logic [31:0]          acc_q [4];
  logic [31:0]          step_q [4];
  logic                 opaque_q;
  logic [COLOR_W-1:0]   res_data_q;
  logic                 res_err_q;
  logic                 out_valid_q;
  logic [COLOR_W-1:0]   read_data_q;
  logic                 error_q;

  logic [COLOR_W-1:0]   mem [MAX_ENTRIES];
  logic [COLOR_W-1:0]   mem_rdata_q;

  logic [NW-1:0]        n;
  logic [AW-1:0]        nm1;
  logic [PRW:0]         psum;
  logic [PW-1:0]        p1w;
  logic [PW-1:0]        p1;
  logic [AW-1:0]        s0;
  logic [AW-1:0]        s1;
  logic [3:0][7:0]      c0b;
  logic [3:0][7:0]      c1b;
  logic [31:0]          acc_n [4];
  logic [3:0][7:0]      ib;
  logic [COLOR_W-1:0]   interp_v;
  logic [7:0]           mag;
  logic                 neg;
  logic                 div_start;
  logic [DVD_W-1:0]     div_q;
  logic                 div_done;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [COLOR_W-1:0]   mem_wdata;
  logic                 in_acc;

  always_comb begin
    if (lut_size_q == '0) begin
      n = NW'(1);
    end else if (NW'(lut_size_q) > NW'(MAX_ENTRIES)) begin
      n = NW'(MAX_ENTRIES);
    end else begin
      n = NW'(lut_size_q);
    end
  end
  assign nm1 = AW'(n - NW'(1));

  assign psum = {1'b0, prod_q} + (PRW + 1)'(128);
  assign p1w  = psum[PW+7:8];
  assign p1   = (p1w < prev_pos_q) ? prev_pos_q : p1w;
  assign s0   = prev_pos_q[PW-1:8];
  assign s1   = p1[PW-1:8];

  assign c0b = c0_q;
  assign c1b = color_q;
  assign mag = (c1b[ch_q] < c0b[ch_q]) ? (c0b[ch_q] - c1b[ch_q]) : (c1b[ch_q] - c0b[ch_q]);
  assign neg = c1b[ch_q] < c0b[ch_q];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      acc_n[i] = acc_q[i] + step_q[i];
      ib[i]    = acc_n[i][30:23];
    end
    interp_v = opaque_q ? {8'hFF, ib[2], ib[1], ib[0]} : premul(ib);
  end

  assign div_start = (state_q == S_DIV);

  glf_div #(
    .DVW (AW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({mag, 23'd0}),
    .divisor_i  (len_q),
    .quotient_o (div_q),
    .done_o     (div_done)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = premul(c0_q);
    unique case (state_q)
      S_CONST, S_START: mem_we = NW'(addr_q) < n;
      S_INTERP: begin
        mem_we    = NW'(addr_q) < n;
        mem_wdata = interp_v;
      end
      S_FIN: begin
        mem_we    = fin_k_q < n;
        mem_waddr = fin_k_q[AW-1:0];
        mem_wdata = premul(prev_color_q);
      end
      S_FIN0: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = first_q;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem[AW'(index_q)];
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      off_q        <= '0;
      color_q      <= '0;
      index_q      <= '0;
      lut_size_q   <= LUT_SIZE_RST;
      prev_color_q <= '0;
      prev_pos_q   <= '0;
      wp_q         <= '0;
      first_q      <= '0;
      stop_seen_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      ch_q         <= '0;
      res_data_q   <= '0;
      res_err_q    <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        lut_size_q <= lut_size_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            off_q      <= (offset_i > OFFSET_ONE) ? OFFSET_ONE : offset_i;
            color_q    <= color_i;
            index_q    <= index_i;
            res_data_q <= '0;
            res_err_q  <= 1'b0;
            fin_k_q    <= wp_q;
            unique case (cmd_e'(command_i))
              CMD_ADD: begin
                if (!stop_seen_q) begin
                  prev_color_q <= color_i;
                  first_q      <= premul(color_i);
                  prev_pos_q   <= '0;
                  stop_seen_q  <= 1'b1;
                end
                state_q <= S_MUL;
              end
              CMD_FINISH: state_q <= S_FIN;
              CMD_READ:   state_q <= S_READ;
              CMD_NONE:   state_q <= S_DONE;
            endcase
          end
        end
        S_MUL: begin
          prod_q  <= PRW'(off_q) * PRW'(nm1);
          state_q <= S_SPAN;
        end
        S_SPAN: begin
          c0_q         <= (s1 == s0) ? color_q : prev_color_q;
          addr_q       <= s0;
          len_q        <= s1 - s0;
          rem_q        <= s1 - s0;
          prev_color_q <= color_q;
          prev_pos_q   <= p1;
          wp_q         <= NW'(s1) + NW'(1);
          if ((s1 == s0) || (prev_color_q == color_q)) begin
            state_q <= S_CONST;
          end else begin
            state_q <= S_START;
          end
        end
        S_CONST: begin
          addr_q <= addr_q + 1'b1;
          rem_q  <= rem_q - 1'b1;
          if (rem_q == '0) begin
            state_q <= S_DONE;
          end
        end
        S_START: begin
          for (int i = 0; i < 4; i++) begin
            acc_q[i] <= {1'b0, c0b[i], 23'd0} + HALF_STEP;
          end
          opaque_q <= (c0b[3] == 8'hFF) && (c1b[3] == 8'hFF);
          addr_q   <= addr_q + 1'b1;
          ch_q     <= '0;
          state_q  <= (len_q == '0) ? S_DONE : S_DIV;
        end
        S_DIV: state_q <= S_DIVWAIT;
        S_DIVWAIT: begin
          if (div_done) begin
            step_q[ch_q] <= neg ? (32'd0 - 32'(div_q)) : 32'(div_q);
            ch_q         <= ch_q + 1'b1;
            state_q      <= (ch_q == 2'd3) ? S_INTERP : S_DIV;
          end
        end
        S_INTERP: begin
          for (int i = 0; i < 4; i++) begin
            acc_q[i] <= acc_n[i];
          end
          addr_q <= addr_q + 1'b1;
          rem_q  <= rem_q - 1'b1;
          if (rem_q == AW'(1)) begin
            state_q <= S_DONE;
          end
        end
        S_FIN: begin
          fin_k_q <= fin_k_q + 1'b1;
          if (fin_k_q >= n) begin
            state_q <= S_FIN0;
          end
        end
        S_FIN0: begin
          prev_color_q <= '0;
          prev_pos_q   <= '0;
          wp_q         <= '0;
          first_q      <= '0;
          stop_seen_q  <= 1'b0;
          state_q      <= S_DONE;
        end
        S_READ: begin
          if (NW'(index_q) < n) begin
            state_q <= S_RWAIT;
          end else begin
            res_err_q <= 1'b1;
            state_q   <= S_DONE;
          end
        end
        S_RWAIT: begin
          res_data_q <= mem_rdata_q;
          state_q    <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            read_data_q <= res_data_q;
            error_q     <= res_err_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;
  assign error_o     = error_q;

  `GLF_ASSERT_NXT(a_accept_busy, in_acc, state_q != S_IDLE, "item taken but sequencer idle")
  `GLF_ASSERT_NOW(a_div_done_wait, div_done, state_q == S_DIVWAIT,
                  "divider result outside wait state")
  `GLF_ASSERT_NOW(a_wr_range, mem_we, NW'(mem_waddr) < NW'(MAX_ENTRIES),
                  "table write beyond depth")
  `GLF_ASSERT_NOW(a_interp_len, state_q == S_INTERP, rem_q != '0,
                  "interpolation with no entries left")

endmodule

>>> rtl/core/glf_div.sv
// Serial restoring divider, one quotient bit per cycle.
`include "assert_macros.svh"

module glf_div #(
  parameter int DVW = 10
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [glf_pkg::DVD_W-1:0] dividend_i,
  input  logic [DVW-1:0]            divisor_i,
  output logic [glf_pkg::DVD_W-1:0] quotient_o,
  output logic                      done_o
);
  import glf_pkg::*;

  localparam int CW = $clog2(DVD_W);

  logic             busy_q;
  logic             done_q;
  logic [CW-1:0]    cnt_q;
  logic [DVW-1:0]   rem_q;
  logic [DVD_W-1:0] dvd_q;
  logic [DVD_W-1:0] quo_q;
  logic [DVW:0]     rem_sh;
  logic             ge;
  logic [DVW:0]     rem_sub;

  assign rem_sh  = {rem_q, dvd_q[DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, divisor_i};
  assign rem_sub = rem_sh - {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dvd_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DVD_W - 1);
        rem_q  <= '0;
        dvd_q  <= dividend_i;
      end else if (busy_q) begin
        rem_q <= ge ? rem_sub[DVW-1:0] : rem_sh[DVW-1:0];
        quo_q <= {quo_q[DVD_W-2:0], ge};
        dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

  `GLF_ASSERT_NOW(a_start_idle, start_i, !busy_q, "divider started while busy")
  `GLF_ASSERT_NOW(a_rem_below, busy_q && divisor_i != '0, rem_q < divisor_i,
                  "remainder not below divisor")
  `GLF_ASSERT_NXT(a_done_idle, done_q, !done_q, "done held over two cycles")

endmodule
